// ----- rtl/dhs_pkg.sv -----
// Shared types and constants for the double-hashing string set.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dhs_pkg;

    // Table geometry. Table sizes are powers of two, so "mod size" is a mask.
    localparam int MAX_SLOTS     = 1024;
    localparam int SLOT_W        = $clog2(MAX_SLOTS);
    localparam int SIZE_W        = SLOT_W + 1;
    localparam int ADDR_W        = SLOT_W + 1;
    localparam int INITIAL_SLOTS = 8;

    // Key format.
    localparam int MAX_CHARS = 8;
    localparam int CHAR_W    = 5;
    localparam int KEY_W     = MAX_CHARS * CHAR_W;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = $clog2(MAX_CHARS);

    // Horner hash constants.
    localparam int HASH_MUL  = 137;
    localparam int MUL_W     = 8;
    localparam int CHAR_BASE = 97;

    // Action codes.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_DEL   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_FAIL = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_KEY   = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

    // One table entry; only the low hash bits matter for slot selection.
    typedef struct packed {
        slot_state_t             kind;
        logic [KEY_W-1:0]        key;
        logic [LEN_W-1:0]        len;
        logic [SLOT_W-1:0]       hash;
    } entry_t;

    // Write request to the slot memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_DECIDE,
        ST_RH_CLEAR,
        ST_RH_RD,
        ST_RH_CHK,
        ST_RH_PRD,
        ST_RH_PCHK,
        ST_RH_END,
        ST_SETUP,
        ST_PRD,
        ST_PCHK,
        ST_RESP
    } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/double_hash_string_set.sv -----
// Top level of the double-hashing string set: sequencer, probe unit, output register.
// Depends on dhs_pkg, dhs_hash and dhs_ram.
//
// Usage: each input transaction (s_action, s_key_chars, s_key_length) adds,
// deletes or queries one key of up to 8 letters; exactly one status
// transaction follows on the m_ channel (0 fail, 1 ok, 2 table full).
// Both channels use valid/ready. s_ready is high only while the sequencer
// is idle, so one transaction is worked on at a time.
// An operation hashes the key letter by letter, then probes the slot
// memory, each probe a read followed by a check; the next transaction
// can be accepted in the same cycle that the status is offered.
// An add that finds the table at 3/4 load first rehashes into the other
// bank: it clears the new bank, reads every old slot and probes for a
// free slot for each key that it moves.
// After reset the block runs a clearing pass over all 2048 memory entries,
// one per cycle, and s_ready stays low until the pass ends.
// A finished status waits in the output register while m_ready is low; the
// block still accepts the next transaction, but does not finish it until
// the pending status has been taken.
`default_nettype none

module double_hash_string_set import dhs_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_action,
    input  wire logic [KEY_W-1:0]  s_key_chars,
    input  wire logic [LEN_W-1:0]  s_key_length,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status
);

    fsm_t                 fsm_reg, fsm_next;
    logic [1:0]           act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [SLOT_W-1:0]    hash_reg, hash_next;
    logic                 bank_reg, bank_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SIZE_W-1:0]    nsize_reg, nsize_next;
    logic [SIZE_W-1:0]    key_cnt_reg, key_cnt_next;
    logic [SIZE_W-1:0]    tomb_cnt_reg, tomb_cnt_next;
    logic [SIZE_W-1:0]    live_reg, live_next;
    logic [SIZE_W-1:0]    cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]    stride_reg, stride_next;
    logic                 have_tomb_reg, have_tomb_next;
    logic [SLOT_W-1:0]    tomb_pos_reg, tomb_pos_next;
    entry_t               mv_reg, mv_next;
    logic [1:0]           res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;

    logic                 accept;
    logic [LEN_W-1:0]     len_sat;
    logic [KEY_W-1:0]     key_masked;
    logic                 item_ok;
    logic                 hash_done;
    logic [SLOT_W-1:0]    hash_out;
    ram_wr_t              wr;
    logic [ADDR_W-1:0]    rd_addr;
    entry_t               rd_data;

    logic [SLOT_W-1:0]    mask, nmask;
    logic [SLOT_W-1:0]    pos_step, npos_step;
    logic [SIZE_W-1:0]    cnt_inc;
    logic                 probe_last, src_last, clear_last, sweep_last;
    logic                 rd_match, rd_empty, rd_tomb;
    logic                 load_high;
    logic [SIZE_W+1:0]    size_x3;
    logic                 resp_load;

    // Input capture: saturate the length and drop letters beyond it.
    always_comb begin
        len_sat = (s_key_length > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : s_key_length;
        for (int k = 0; k < MAX_CHARS; k++) begin
            key_masked[k*CHAR_W +: CHAR_W] =
                (LEN_W'(k) < len_sat) ? s_key_chars[k*CHAR_W +: CHAR_W] : '0;
        end
        item_ok = (len_sat != '0) &&
                  (s_action == ACT_ADD || s_action == ACT_DEL || s_action == ACT_QUERY);
    end

    assign s_ready = (fsm_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    dhs_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && item_ok),
        .key     (key_masked),
        .len     (len_sat),
        .done    (hash_done),
        .hash    (hash_out)
    );

    dhs_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared probe arithmetic: masks, next probe position and loop ends.
    always_comb begin
        mask       = size_reg[SLOT_W-1:0] - SLOT_W'(1);
        nmask      = nsize_reg[SLOT_W-1:0] - SLOT_W'(1);
        pos_step   = (pos_reg + stride_reg) & mask;
        npos_step  = (pos_reg + stride_reg) & nmask;
        cnt_inc    = cnt_reg + SIZE_W'(1);
        probe_last = (cnt_inc == size_reg);
        src_last   = (cnt_inc == size_reg);
        clear_last = (cnt_reg == nsize_reg - SIZE_W'(1));
        sweep_last = (cnt_reg[ADDR_W-1:0] == {ADDR_W{1'b1}});
        rd_empty   = (rd_data.kind == SLOT_EMPTY);
        rd_tomb    = (rd_data.kind == SLOT_TOMB);
        rd_match   = (rd_data.kind == SLOT_KEY) && (rd_data.len == len_reg) &&
                     (rd_data.key == key_reg);
        size_x3    = ({2'b00, size_reg} << 1) + {2'b00, size_reg};
        load_high  = ({key_cnt_reg, 2'b00} >= size_x3);
        resp_load  = !m_valid_reg || m_ready;
    end

    // Next state.
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            ST_CLEAR:    if (sweep_last) fsm_next = ST_IDLE;
            ST_IDLE:     if (accept) fsm_next = item_ok ? ST_HASH : ST_RESP;
            ST_HASH:     if (hash_done) fsm_next = ST_DECIDE;
            ST_DECIDE:   fsm_next = (act_reg == ACT_ADD && load_high) ? ST_RH_CLEAR : ST_SETUP;
            ST_RH_CLEAR: if (clear_last) fsm_next = ST_RH_RD;
            ST_RH_RD:    fsm_next = ST_RH_CHK;
            ST_RH_CHK: begin
                if (rd_data.kind == SLOT_KEY) fsm_next = ST_RH_PRD;
                else if (src_last)            fsm_next = ST_RH_END;
                else                          fsm_next = ST_RH_RD;
            end
            ST_RH_PRD:   fsm_next = ST_RH_PCHK;
            ST_RH_PCHK: begin
                if (!rd_empty)     fsm_next = ST_RH_PRD;
                else if (src_last) fsm_next = ST_RH_END;
                else               fsm_next = ST_RH_RD;
            end
            ST_RH_END:   fsm_next = ST_SETUP;
            ST_SETUP:    fsm_next = ST_PRD;
            ST_PRD:      fsm_next = ST_PCHK;
            ST_PCHK: begin
                if (act_reg == ACT_ADD) begin
                    if (rd_empty || rd_match || probe_last) fsm_next = ST_RESP;
                    else                                    fsm_next = ST_PRD;
                end else begin
                    if (rd_empty || rd_match || probe_last) fsm_next = ST_RESP;
                    else                                    fsm_next = ST_PRD;
                end
            end
            ST_RESP:     if (resp_load) fsm_next = ST_IDLE;
            default:     fsm_next = ST_IDLE;
        endcase
    end

    // Outputs: datapath updates and memory accesses.
    always_comb begin
        act_next       = act_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;
        bank_next      = bank_reg;
        size_next      = size_reg;
        nsize_next     = nsize_reg;
        key_cnt_next   = key_cnt_reg;
        tomb_cnt_next  = tomb_cnt_reg;
        live_next      = live_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        stride_next    = stride_reg;
        have_tomb_next = have_tomb_reg;
        tomb_pos_next  = tomb_pos_reg;
        mv_next        = mv_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        wr             = '0;
        rd_addr        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (fsm_reg)
            // Power-up sweep marks every slot of both banks empty.
            ST_CLEAR: begin
                wr.en    = 1'b1;
                wr.addr  = cnt_reg[ADDR_W-1:0];
                cnt_next = cnt_inc;
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next = s_action;
                    key_next = key_masked;
                    len_next = len_sat;
                    res_next = STATUS_FAIL;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    hash_next = hash_out;
                end
            end
            // Rehash size: same if tombstones fill half, else double up to the cap.
            ST_DECIDE: begin
                if ({tomb_cnt_reg, 1'b0} >= {1'b0, size_reg} ||
                    size_reg == SIZE_W'(MAX_SLOTS)) begin
                    nsize_next = size_reg;
                end else begin
                    nsize_next = size_reg << 1;
                end
                cnt_next = '0;
            end
            ST_RH_CLEAR: begin
                wr.en    = 1'b1;
                wr.addr  = {~bank_reg, cnt_reg[SLOT_W-1:0]};
                cnt_next = clear_last ? '0 : cnt_inc;
                live_next = '0;
            end
            ST_RH_RD: begin
                rd_addr = {bank_reg, cnt_reg[SLOT_W-1:0]};
            end
            ST_RH_CHK: begin
                if (rd_data.kind == SLOT_KEY) begin
                    mv_next     = rd_data;
                    pos_next    = rd_data.hash & nmask;
                    stride_next = {rd_data.hash[SLOT_W-2:0], 1'b1} & nmask;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            ST_RH_PRD: begin
                rd_addr = {~bank_reg, pos_reg};
            end
            ST_RH_PCHK: begin
                if (rd_empty) begin
                    wr.en     = 1'b1;
                    wr.addr   = {~bank_reg, pos_reg};
                    wr.data   = mv_reg;
                    live_next = live_reg + SIZE_W'(1);
                    cnt_next  = cnt_inc;
                end else begin
                    pos_next = npos_step;
                end
            end
            ST_RH_END: begin
                bank_next     = ~bank_reg;
                size_next     = nsize_reg;
                key_cnt_next  = live_reg;
                tomb_cnt_next = '0;
            end
            ST_SETUP: begin
                pos_next       = hash_reg & mask;
                stride_next    = {hash_reg[SLOT_W-2:0], 1'b1} & mask;
                cnt_next       = '0;
                have_tomb_next = 1'b0;
            end
            ST_PRD: begin
                rd_addr = {bank_reg, pos_reg};
            end
            // Probe check for add, delete and query.
            ST_PCHK: begin
                wr.data.kind = SLOT_KEY;
                wr.data.key  = key_reg;
                wr.data.len  = len_reg;
                wr.data.hash = hash_reg;
                cnt_next     = cnt_inc;
                pos_next     = pos_step;
                if (act_reg == ACT_ADD) begin
                    if (rd_tomb && !have_tomb_reg) begin
                        have_tomb_next = 1'b1;
                        tomb_pos_next  = pos_reg;
                    end
                    if (rd_match) begin
                        res_next = STATUS_FAIL;
                    end else if (rd_empty || (probe_last && (have_tomb_reg || rd_tomb))) begin
                        wr.en        = 1'b1;
                        wr.addr      = {bank_reg,
                                        have_tomb_reg ? tomb_pos_reg : pos_reg};
                        key_cnt_next = key_cnt_reg + SIZE_W'(1);
                        res_next     = STATUS_OK;
                    end else if (probe_last) begin
                        res_next = STATUS_FULL;
                    end
                end else begin
                    if (rd_match) begin
                        res_next = STATUS_OK;
                        if (act_reg == ACT_DEL) begin
                            wr.en         = 1'b1;
                            wr.addr       = {bank_reg, pos_reg};
                            wr.data       = rd_data;
                            wr.data.kind  = SLOT_TOMB;
                            tomb_cnt_next = tomb_cnt_reg + SIZE_W'(1);
                        end
                    end else begin
                        res_next = STATUS_FAIL;
                    end
                end
            end
            ST_RESP: begin
                if (resp_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= ST_CLEAR;
            bank_reg     <= 1'b0;
            size_reg     <= SIZE_W'(INITIAL_SLOTS);
            key_cnt_reg  <= '0;
            tomb_cnt_reg <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            fsm_reg      <= fsm_next;
            bank_reg     <= bank_next;
            size_reg     <= size_next;
            key_cnt_reg  <= key_cnt_next;
            tomb_cnt_reg <= tomb_cnt_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        act_reg       <= act_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        hash_reg      <= hash_next;
        nsize_reg     <= nsize_next;
        live_reg      <= live_next;
        pos_reg       <= pos_next;
        stride_reg    <= stride_next;
        have_tomb_reg <= have_tomb_next;
        tomb_pos_reg  <= tomb_pos_next;
        mv_reg        <= mv_next;
        res_reg       <= res_next;
        m_status_reg  <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

// ----- rtl/dhs_hash.sv -----
// Iterative Horner hash unit: one letter per cycle, low table bits only.
// Depends on dhs_pkg.
`default_nettype none

module dhs_hash import dhs_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [LEN_W-1:0]  len,
    output logic                   done,
    output logic [SLOT_W-1:0]      hash
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [SLOT_W-1:0]    h_reg, h_next;
    logic [CHAR_W-1:0]    ch;
    logic [SLOT_W+MUL_W-1:0] prod;
    logic [SLOT_W-1:0]    h_step;

    // One Horner step: h = h * 137 + ('a' + letter), kept modulo the table range.
    always_comb begin
        ch     = key_reg[idx_reg*CHAR_W +: CHAR_W];
        prod   = {{MUL_W{1'b0}}, h_reg} * (SLOT_W+MUL_W)'(HASH_MUL);
        h_step = prod[SLOT_W-1:0] + SLOT_W'(CHAR_BASE) + SLOT_W'(ch);
    end

    // Step sequencing.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        last_next = last_reg;
        key_next  = key_reg;
        h_next    = h_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            last_next = IDX_W'(len - LEN_W'(1));
            key_next  = key;
            h_next    = '0;
        end else if (busy_reg) begin
            h_next   = h_step;
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == last_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        idx_reg  <= idx_next;
        last_reg <= last_next;
        key_reg  <= key_next;
        h_reg    <= h_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

`default_nettype wire

// ----- rtl/dhs_ram.sv -----
// Slot memory for both banks: one write port, one registered read port.
// Depends on dhs_pkg.
`default_nettype none

module dhs_ram import dhs_pkg::*; (
    input  wire logic              aclk,
    input  wire ram_wr_t           wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [2*MAX_SLOTS];
    entry_t rd_data_reg;

    // Write and read in the same clocked block; read returns old data.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/dhs_checker.sv -----
// Port-level checks for the double-hashing string set, bound to the top level.
// Depends on dhs_pkg and double_hash_string_set.
`default_nettype none

module dhs_checker import dhs_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [1:0]        m_status
);

    // No status is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an accepted transaction");

    // A stalled status holds.
    a_status_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("status changed while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_FAIL || m_status == STATUS_OK ||
                     m_status == STATUS_FULL))
        else $error("undefined status code");

endmodule

bind double_hash_string_set dhs_checker u_dhs_checker (.*);

`default_nettype wire
